[rtl/gca_pkg.sv]
// shared types, codes and table generators for the gamma color arithmetic block
package gca_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [2:0] K_ADD  = 3'd0;
    localparam logic [2:0] K_SUB  = 3'd1;
    localparam logic [2:0] K_MUL  = 3'd2;
    localparam logic [2:0] K_DIV  = 3'd3;
    localparam logic [2:0] K_PASS = 3'd4;
    localparam logic [2:0] K_ZERO = 3'd5;

    localparam int LIN_INT_BITS = 18;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  alpha;
        logic [22:0] scale_mag;
        logic [31:0] color;
    } t_task_ctl;

    function automatic logic [255:0] big_pow(logic [255:0] b, int e);
        logic [255:0] r;
        r = 256'd1;
        for (int i = 0; i < e; i++) begin
            r = r * b;
        end
        return r;
    endfunction

    // round(k^2.2 * 2^f), ties upward
    function automatic logic [63:0] lin_entry(int k, int f);
        logic [255:0] rhs;
        logic [255:0] lhs;
        logic [255:0] lo;
        logic [255:0] hi;
        logic [255:0] mid;
        if (k == 0) begin
            return 64'd0;
        end
        rhs = big_pow(256'(k), 11) << (5 * f + 5);
        lo = 256'd0;
        hi = 256'd1 << (f + LIN_INT_BITS);
        while (lo < hi) begin
            mid = lo + ((hi - lo + 256'd1) >> 1);
            lhs = big_pow((mid << 1) - 256'd1, 5);
            if (lhs <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 256'd1;
            end
        end
        return lo[63:0];
    endfunction

    // ceil((k - 0.5)^2.2 * 2^f)
    function automatic logic [63:0] thr_entry(int k, int f);
        logic [255:0] rhs;
        logic [255:0] lhs;
        logic [255:0] lo;
        logic [255:0] hi;
        logic [255:0] mid;
        if (k == 0) begin
            return 64'd0;
        end
        rhs = big_pow(256'(2 * k - 1), 11) << (5 * f);
        lo = 256'd1;
        hi = 256'd1 << (f + LIN_INT_BITS);
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            lhs = big_pow(mid, 5) << 11;
            if (lhs >= rhs) begin
                hi = mid;
            end else begin
                lo = mid + 256'd1;
            end
        end
        return lo[63:0];
    endfunction

endpackage

[rtl/gca_queue.sv]
// small first-in first-out queue between pipeline parts
module gca_queue import gca_pkg::*; #(
    parameter int W = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (wr_en) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (rd_en) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

[rtl/gca_front.sv]
// front part: decodes a request, looks up linear values and settles alpha (divide alpha is found in the back)
module gca_front import gca_pkg::*; #(
    parameter int LINEAR_FRAC_BITS = 8,
    parameter int SCALE_FRAC_BITS = 16
) (
    input  logic [1:0]                                    i_operation,
    input  logic [31:0]                                   i_first_color,
    input  logic [31:0]                                   i_second_color,
    input  logic signed [23:0]                            i_scale,
    output t_task_ctl                                     o_ctl,
    output logic [3*(LIN_INT_BITS+LINEAR_FRAC_BITS)-1:0]  o_lin1,
    output logic [3*(LIN_INT_BITS+LINEAR_FRAC_BITS)-1:0]  o_lin2
);

    localparam int LW = LIN_INT_BITS + LINEAR_FRAC_BITS;
    localparam int SF = SCALE_FRAC_BITS;

    typedef logic [LW-1:0] t_rom [256];

    function automatic t_rom build_lin();
        t_rom        r;
        logic [63:0] v;
        for (int k = 0; k < 256; k++) begin
            v = lin_entry(k, LINEAR_FRAC_BITS);
            r[k] = v[LW-1:0];
        end
        return r;
    endfunction

    localparam t_rom LIN_ROM = build_lin();

    logic [7:0]  a1, a2;
    logic [8:0]  a_sum;
    logic [31:0] a_prod;
    logic [31:0] a_quot;
    logic        s_neg, s_zero;

    assign a1     = i_first_color[31:24];
    assign a2     = i_second_color[31:24];
    assign s_neg  = i_scale[23];
    assign s_zero = (i_scale == '0);
    assign a_sum  = {1'b0, a1} + {1'b0, a2};
    assign a_prod = 32'(a1) * 32'(i_scale[22:0]) + (32'd1 << (SF - 1));
    assign a_quot = a_prod >> SF;

    always_comb begin
        o_ctl.color     = i_first_color;
        o_ctl.scale_mag = i_scale[22:0];
        o_ctl.alpha     = '0;
        o_ctl.kind      = K_ZERO;
        case (i_operation)
            OP_ADD: begin
                o_ctl.kind  = K_ADD;
                o_ctl.alpha = a_sum[8] ? 8'hff : a_sum[7:0];
            end
            OP_SUB: begin
                o_ctl.kind  = K_SUB;
                o_ctl.alpha = (a1 >= a2) ? a1 - a2 : 8'd0;
            end
            OP_MUL: begin
                if (!s_neg && !s_zero) begin
                    o_ctl.kind  = K_MUL;
                    o_ctl.alpha = (a_quot > 32'd255) ? 8'hff : a_quot[7:0];
                end
            end
            OP_DIV: begin
                if (s_zero) begin
                    o_ctl.kind = K_PASS;
                end else if (!s_neg) begin
                    o_ctl.kind = K_DIV;
                end
            end
            default: o_ctl.kind = K_ZERO;
        endcase
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            o_lin1[ch*LW +: LW] = LIN_ROM[i_first_color[16-8*ch +: 8]];
            o_lin2[ch*LW +: LW] = LIN_ROM[i_second_color[16-8*ch +: 8]];
        end
    end

endmodule

[rtl/gca_back.sv]
// back part: per-channel setup and threshold search with one shared multiplier
module gca_back import gca_pkg::*; #(
    parameter int LINEAR_FRAC_BITS = 8,
    parameter int SCALE_FRAC_BITS = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_task_empty,
    input  t_task_ctl                                     i_ctl,
    input  logic [3*(LIN_INT_BITS+LINEAR_FRAC_BITS)-1:0]  i_lin1,
    input  logic [3*(LIN_INT_BITS+LINEAR_FRAC_BITS)-1:0]  i_lin2,
    output logic                                          o_task_pop,
    input  logic                                          i_res_full,
    output logic                                          o_res_push,
    output logic [31:0]                                   o_res
);

    localparam int LW  = LIN_INT_BITS + LINEAR_FRAC_BITS;
    localparam int SF  = SCALE_FRAC_BITS;
    localparam int MW  = (SF + 1 > 24) ? SF + 1 : 24;
    localparam int LHW = LW + MW + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_STEP  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam logic [1:0] U_ALPHA = 2'd3;

    typedef logic [LW-1:0] t_rom [256];

    function automatic t_rom build_thr();
        t_rom        r;
        logic [63:0] v;
        for (int k = 0; k < 256; k++) begin
            v = thr_entry(k, LINEAR_FRAC_BITS);
            r[k] = v[LW-1:0];
        end
        return r;
    endfunction

    localparam t_rom THR_ROM = build_thr();

    logic [1:0]         r_state, n_state;
    logic [1:0]         r_unit, n_unit;
    logic [2:0]         r_bit, n_bit;
    logic [7:0]         r_g, n_g;
    logic [LHW-1:0]     r_lhs, n_lhs;
    logic [MW-1:0]      r_mfac, n_mfac;
    t_task_ctl          r_ctl, n_ctl;
    logic [3*LW-1:0]    r_lin1, n_lin1;
    logic [3*LW-1:0]    r_lin2, n_lin2;
    logic [31:0]        r_res, n_res;

    logic [LW-1:0]      l1, l2;
    logic [7:0]         cand;
    logic [LW-1:0]      tval;
    logic [LW+MW-1:0]   rhs;
    logic               take;
    logic [7:0]         g_new;
    logic [1:0]         byte_idx;

    assign o_task_pop = (r_state == S_IDLE) && !i_task_empty;
    assign o_res_push = (r_state == S_DONE);
    assign o_res      = r_res;

    assign l1       = r_lin1[r_unit*LW +: LW];
    assign l2       = r_lin2[r_unit*LW +: LW];
    assign cand     = r_g | (8'd1 << r_bit);
    assign tval     = (r_unit == U_ALPHA) ? LW'(cand) : THR_ROM[cand];
    assign rhs      = tval * r_mfac;
    assign take     = (r_lhs >= LHW'(rhs));
    assign g_new    = take ? cand : r_g;
    assign byte_idx = (r_unit == U_ALPHA) ? 2'd3 : 2'd2 - r_unit;

    always_comb begin
        n_state = r_state;
        n_unit  = r_unit;
        n_bit   = r_bit;
        n_g     = r_g;
        n_lhs   = r_lhs;
        n_mfac  = r_mfac;
        n_ctl   = r_ctl;
        n_lin1  = r_lin1;
        n_lin2  = r_lin2;
        n_res   = r_res;
        case (r_state)
            S_IDLE: begin
                if (!i_task_empty) begin
                    n_ctl  = i_ctl;
                    n_lin1 = i_lin1;
                    n_lin2 = i_lin2;
                    n_unit = '0;
                    n_res  = {i_ctl.alpha, 24'd0};
                    if (i_ctl.kind == K_PASS) begin
                        n_res   = i_ctl.color;
                        n_state = S_DONE;
                    end else if (i_ctl.kind == K_ZERO) begin
                        n_res   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                n_g     = '0;
                n_bit   = 3'd7;
                n_state = S_STEP;
                case (r_ctl.kind)
                    K_ADD: begin
                        n_lhs  = LHW'(l1) + LHW'(l2);
                        n_mfac = MW'(1);
                    end
                    K_SUB: begin
                        n_lhs  = (l1 >= l2) ? LHW'(l1 - l2) : '0;
                        n_mfac = MW'(1);
                    end
                    K_MUL: begin
                        n_lhs  = LHW'(l1) * LHW'(r_ctl.scale_mag);
                        n_mfac = MW'(1) << SF;
                    end
                    default: begin
                        if (r_unit == U_ALPHA) begin
                            n_lhs  = (LHW'(r_ctl.color[31:24]) << (SF + 1))
                                     + LHW'(r_ctl.scale_mag);
                            n_mfac = MW'(r_ctl.scale_mag) << 1;
                        end else begin
                            n_lhs  = LHW'(l1) << SF;
                            n_mfac = MW'(r_ctl.scale_mag);
                        end
                    end
                endcase
            end
            S_STEP: begin
                n_g   = g_new;
                n_bit = r_bit - 3'd1;
                if (r_bit == 3'd0) begin
                    n_res[byte_idx*8 +: 8] = g_new;
                    if (r_unit == 2'd2 && r_ctl.kind == K_DIV) begin
                        n_unit  = U_ALPHA;
                        n_state = S_SETUP;
                    end else if (r_unit < 2'd2) begin
                        n_unit  = r_unit + 2'd1;
                        n_state = S_SETUP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_unit <= n_unit;
        r_bit  <= n_bit;
        r_g    <= n_g;
        r_lhs  <= n_lhs;
        r_mfac <= n_mfac;
        r_ctl  <= n_ctl;
        r_lin1 <= n_lin1;
        r_lin2 <= n_lin2;
        r_res  <= n_res;
    end

    a_alpha_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && r_unit == U_ALPHA) |-> r_ctl.kind == K_DIV)
        else $error("alpha search on a non-divide request");

    a_setup_to_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SETUP |=> r_state == S_STEP)
        else $error("setup not followed by search");

    a_last_unit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && r_bit == 3'd0 && r_unit == 2'd2 && r_ctl.kind != K_DIV)
        |=> r_state == S_DONE)
        else $error("blue channel finished without completion");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_task_pop |=> r_state != S_IDLE)
        else $error("popped request not taken");

endmodule

[rtl/gamma_color_arithmetic.sv]
// top level: gamma 2.2 linear-light color arithmetic on packed ARGB requests
//
// requests enter through push/full; a request is taken when push is high
// and full is low. results leave through empty/pop: the oldest result sits
// on o_result_color while empty is low and is taken when pop is high.
// the front decodes a request in the cycle it is taken and places it in a
// two-entry queue; the back works one request at a time. each RGB channel
// takes a setup step plus an eight-step threshold search against one
// threshold multiplier shared by the channels, and divide adds a fourth search
// for alpha; pass-through and zero results skip the search and go straight
// to the output handoff.
// divide by a zero scale returns the first color unchanged.
// results wait in a two-entry output queue; when the receiver stalls the
// back holds its finished result and the front keeps filling its queue
// until full rises. synchronous reset empties both queues and idles the back.
module gamma_color_arithmetic import gca_pkg::*; #(
    parameter int LINEAR_FRAC_BITS = 8,
    parameter int SCALE_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_operation,
    input  logic [31:0]         i_first_color,
    input  logic [31:0]         i_second_color,
    input  logic signed [23:0]  i_scale,
    output logic                empty,
    input  logic                pop,
    output logic [31:0]         o_result_color
);

    localparam int LW = LIN_INT_BITS + LINEAR_FRAC_BITS;
    localparam int CW = $bits(t_task_ctl);
    localparam int TW = CW + 6 * LW;

    t_task_ctl       front_ctl, back_ctl;
    logic [3*LW-1:0] front_lin1, front_lin2;
    logic [3*LW-1:0] back_lin1, back_lin2;
    logic [TW-1:0]   task_out;
    logic            task_empty, task_pop;
    logic            res_push, res_full;
    logic [31:0]     res_data;

    gca_front #(
        .LINEAR_FRAC_BITS (LINEAR_FRAC_BITS),
        .SCALE_FRAC_BITS  (SCALE_FRAC_BITS)
    ) u_front (
        .i_operation    (i_operation),
        .i_first_color  (i_first_color),
        .i_second_color (i_second_color),
        .i_scale        (i_scale),
        .o_ctl          (front_ctl),
        .o_lin1         (front_lin1),
        .o_lin2         (front_lin2)
    );

    gca_queue #(
        .W     (TW),
        .DEPTH (2)
    ) u_task_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_ctl, front_lin1, front_lin2}),
        .o_full  (full),
        .i_pop   (task_pop),
        .o_data  (task_out),
        .o_empty (task_empty)
    );

    assign back_ctl  = task_out[TW-1 -: CW];
    assign back_lin1 = task_out[6*LW-1 -: 3*LW];
    assign back_lin2 = task_out[3*LW-1:0];

    gca_back #(
        .LINEAR_FRAC_BITS (LINEAR_FRAC_BITS),
        .SCALE_FRAC_BITS  (SCALE_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_empty (task_empty),
        .i_ctl        (back_ctl),
        .i_lin1       (back_lin1),
        .i_lin2       (back_lin2),
        .o_task_pop   (task_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res_data)
    );

    gca_queue #(
        .W     (32),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result_color),
        .o_empty (empty)
    );

endmodule
